FILE: rtl/core/qda_pkg.sv
// Shared types, request codes, register map and noise tables of the QUBO annealer.
// Depends on nothing; every other file refers to it by scoped names.
package qda_pkg;

  localparam int DEF_NUM_SPINS   = 32;
  localparam int DEF_COEF_WIDTH  = 16;
  localparam int DEF_FIELD_WIDTH = 24;

  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam longint LN2_Q16 = 45426;

  localparam logic [15:0] TEMPERATURE_RST  = 16'd2133;
  localparam logic [15:0] OFFSET_STEP_RST  = 16'd512;
  localparam logic [15:0] OFFSET_LIMIT_RST = 16'd5120;
  localparam logic [31:0] RNG_SEED_RST     = 32'd1;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_INIT   = 2'd2,
    REQ_SWEEP  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_TEMPERATURE  = 3'd0,
    REG_OFFSET_STEP  = 3'd1,
    REG_OFFSET_LIMIT = 3'd2,
    REG_ACCEPT_MODE  = 3'd3,
    REG_RNG_SEED     = 3'd4
  } reg_e;

  typedef struct packed {
    logic [15:0] temperature;
    logic [15:0] offset_step;
    logic [15:0] offset_limit;
    logic        accept_mode;
    logic [31:0] rng_seed;
  } cfg_t;

  typedef logic signed [15:0] tbl_t [256];

  // Integer natural log in Q.8, from a log2 found by repeated squaring.
  function automatic longint ln_q8(longint unsigned n);
    int msb;
    longint unsigned x;
    longint r;
    msb = 0;
    for (int b = 0; b < 32; b++) begin
      if ((n >> b) != 0) msb = b;
    end
    x = n << (30 - msb);
    r = longint'(msb) * 65536;
    for (int k = 15; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        r = r + (longint'(1) << k);
      end
    end
    return (r * LN2_Q16 + (longint'(1) << 23)) >>> 24;
  endfunction

  function automatic tbl_t build_tbl(logic gibbs);
    tbl_t t;
    longint lr;
    for (int u = 0; u < 256; u++) begin
      lr = ln_q8(longint'(2 * u + 1));
      if (gibbs) t[u] = 16'(ln_q8(longint'(511 - 2 * u)) - lr);
      else       t[u] = 16'(ln_q8(64'd512) - lr);
    end
    return t;
  endfunction

  localparam tbl_t METRO_TBL = build_tbl(1'b0);
  localparam tbl_t GIBBS_TBL = build_tbl(1'b1);

endpackage

FILE: rtl/core/qubo_digital_annealer_top.sv
// Top level of the QUBO annealer: configuration registers and the annealing engine.
// Depends on qda_pkg, qda_cfg_regs and qda_engine.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------------
//  request   | start in, busy out      | req_type, row_index, col_index, coef_value,
//            |                         | start_spins
//  result    | done out (one cycle)    | flip_done, flip_position, spin_vector,
//            |                         | offset_now
//  config    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// A request is taken when start is high and busy is low; its result follows with done.
// Weight and bias loads raise done in the cycle after they are taken. A start-spin load reads
// each spin's bias and couplings, one coupling read at a time through the single read port.
// A sweep runs field read, threshold multiply and compare for each spin in turn for
// acceptance, then a field update over every spin when a spin flips.
// Reset is synchronous and needs no clearing pass; the result side cannot stall.
module qubo_digital_annealer_top #(
  parameter int NUM_SPINS   = qda_pkg::DEF_NUM_SPINS,
  parameter int COEF_WIDTH  = qda_pkg::DEF_COEF_WIDTH,
  parameter int FIELD_WIDTH = qda_pkg::DEF_FIELD_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [4:0]         row_index,
  input  logic [4:0]         col_index,
  input  logic signed [15:0] coef_value,
  input  logic [31:0]        start_spins,
  output logic               done,
  output logic               flip_done,
  output logic [4:0]         flip_position,
  output logic [31:0]        spin_vector,
  output logic [15:0]        offset_now,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  qda_pkg::cfg_t cfg;

  qda_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qda_engine #(
    .NUM_SPINS   (NUM_SPINS),
    .COEF_WIDTH  (COEF_WIDTH),
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .req_type      (req_type),
    .row_index     (row_index),
    .col_index     (col_index),
    .coef_value    (coef_value),
    .start_spins   (start_spins),
    .busy          (busy),
    .done          (done),
    .flip_done     (flip_done),
    .flip_position (flip_position),
    .spin_vector   (spin_vector),
    .offset_now    (offset_now)
  );

endmodule

FILE: rtl/core/qda_cfg_regs.sv
// APB-style configuration registers of the QUBO annealer.
// Depends on qda_pkg for the register map and the configuration struct.
module qda_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output qda_pkg::cfg_t   cfg
);

  logic wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temperature  <= qda_pkg::TEMPERATURE_RST;
      cfg.offset_step  <= qda_pkg::OFFSET_STEP_RST;
      cfg.offset_limit <= qda_pkg::OFFSET_LIMIT_RST;
      cfg.accept_mode  <= 1'b0;
      cfg.rng_seed     <= qda_pkg::RNG_SEED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        qda_pkg::REG_TEMPERATURE:  cfg.temperature  <= pwdata[15:0];
        qda_pkg::REG_OFFSET_STEP:  cfg.offset_step  <= pwdata[15:0];
        qda_pkg::REG_OFFSET_LIMIT: cfg.offset_limit <= pwdata[15:0];
        qda_pkg::REG_ACCEPT_MODE:  cfg.accept_mode  <= pwdata[0];
        qda_pkg::REG_RNG_SEED:     cfg.rng_seed     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qda_pkg::REG_TEMPERATURE:  prdata = {16'd0, cfg.temperature};
      qda_pkg::REG_OFFSET_STEP:  prdata = {16'd0, cfg.offset_step};
      qda_pkg::REG_OFFSET_LIMIT: prdata = {16'd0, cfg.offset_limit};
      qda_pkg::REG_ACCEPT_MODE:  prdata = {31'd0, cfg.accept_mode};
      qda_pkg::REG_RNG_SEED:     prdata = cfg.rng_seed;
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/core/qda_engine.sv
// Sequencer, coefficient and field memories, field add/saturate and acceptance compare logic.
// Depends on qda_pkg for request codes, configuration struct and noise tables.
module qda_engine #(
  parameter int NUM_SPINS   = qda_pkg::DEF_NUM_SPINS,
  parameter int COEF_WIDTH  = qda_pkg::DEF_COEF_WIDTH,
  parameter int FIELD_WIDTH = qda_pkg::DEF_FIELD_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  qda_pkg::cfg_t       cfg,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  logic [4:0]          row_index,
  input  logic [4:0]          col_index,
  input  logic signed [15:0]  coef_value,
  input  logic [31:0]         start_spins,
  output logic                busy,
  output logic                done,
  output logic                flip_done,
  output logic [4:0]          flip_position,
  output logic [31:0]         spin_vector,
  output logic [15:0]         offset_now
);

  localparam int IDX_W     = (NUM_SPINS > 1) ? $clog2(NUM_SPINS) : 1;
  localparam int CPL_DEPTH = 1 << (2 * IDX_W);
  localparam int SUM_W     = COEF_WIDTH + $clog2(NUM_SPINS + 1) + 1;
  localparam int WIDE_W    = ((SUM_W > FIELD_WIDTH + 1) ? SUM_W : FIELD_WIDTH + 1) + 1;
  localparam int CMP_W     = (FIELD_WIDTH + 11 > 35) ? FIELD_WIDTH + 11 : 35;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SPINS - 1);

  localparam logic signed [32:0] CHI = (33'sd1 <<< (COEF_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] CLO = -CHI - 33'sd1;
  localparam logic signed [WIDE_W-1:0] FHI =
    (WIDE_W'(1) << (FIELD_WIDTH - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] FLO = -FHI - WIDE_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_BRD, S_INIT_BACC, S_INIT_CRD, S_INIT_CACC, S_INIT_WR,
    S_ACC_RD, S_ACC_MUL, S_ACC_CMP, S_UPD_RD, S_UPD_WR
  } state_t;

  function automatic logic signed [FIELD_WIDTH-1:0] sat_field(
    logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = (v > FHI) ? FHI : ((v < FLO) ? FLO : v);
    return c[FIELD_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] lfsr_step8(logic [31:0] s);
    logic [31:0] t;
    t = s;
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ qda_pkg::LFSR_MASK) : (t >> 1);
    end
    return t;
  endfunction

  state_t state;
  logic [NUM_SPINS-1:0] spins;
  logic [15:0] offset;
  logic [31:0] lfsr;
  logic [IDX_W-1:0] i, j, kept;
  logic have, up;
  logic signed [WIDE_W-1:0] acc;
  logic signed [FIELD_WIDTH:0] de_r;
  logic signed [32:0] thr_r;
  logic coin_r;

  logic signed [COEF_WIDTH-1:0] cpl_mem [CPL_DEPTH];
  logic signed [COEF_WIDTH-1:0] bias_mem [NUM_SPINS];
  logic signed [FIELD_WIDTH-1:0] lf_mem [NUM_SPINS];
  logic signed [COEF_WIDTH-1:0] cpl_rdata, bias_rdata;
  logic signed [FIELD_WIDTH-1:0] lf_rdata;
  logic [2*IDX_W-1:0] cpl_raddr, cpl_waddr;
  logic cpl_we, bias_we, lf_we;
  logic signed [FIELD_WIDTH-1:0] lf_wdata;

  logic signed [32:0] coef_ext;
  logic signed [COEF_WIDTH-1:0] coef_sat;
  logic row_ok, col_ok;
  logic signed [15:0] tbl_val;
  logic signed [CMP_W-1:0] lhs;
  logic accept, take, have_f;
  logic [IDX_W-1:0] kept_f;
  logic [16:0] off_sum;
  logic signed [WIDE_W-1:0] upd_sum;

  assign busy = (state != S_IDLE);
  assign coef_ext = {{17{coef_value[15]}}, coef_value};
  assign coef_sat = COEF_WIDTH'((coef_ext > CHI) ? CHI : ((coef_ext < CLO) ? CLO : coef_ext));
  assign row_ok = (7'(row_index) < 7'(NUM_SPINS));
  assign col_ok = (7'(col_index) < 7'(NUM_SPINS));
  assign cpl_waddr = {IDX_W'(row_index), IDX_W'(col_index)};
  assign cpl_raddr = (state == S_UPD_RD) ? {i, kept} : {i, j};

  assign cpl_we  = (state == S_IDLE) && start &&
                   (req_type == qda_pkg::REQ_WEIGHT) && row_ok && col_ok;
  assign bias_we = (state == S_IDLE) && start &&
                   (req_type == qda_pkg::REQ_BIAS) && row_ok;

  // Field write path: init writes the saturated accumulator, update the saturated add or subtract.
  assign upd_sum = up ? (WIDE_W'(lf_rdata) + WIDE_W'(cpl_rdata))
                      : (WIDE_W'(lf_rdata) - WIDE_W'(cpl_rdata));
  assign lf_we    = (state == S_INIT_WR) || (state == S_UPD_WR);
  assign lf_wdata = (state == S_INIT_WR) ? sat_field(acc) : sat_field(upd_sum);

  assign tbl_val = cfg.accept_mode ? qda_pkg::GIBBS_TBL[lfsr[7:0]]
                                   : qda_pkg::METRO_TBL[lfsr[7:0]];
  assign lhs = (CMP_W'(de_r) - CMP_W'($signed({1'b0, offset}))) <<< 8;
  assign accept = (lhs < CMP_W'(thr_r));
  assign take   = accept && (!have || coin_r);
  assign have_f = have || accept;
  assign kept_f = take ? i : kept;
  assign off_sum = 17'(offset) + 17'(cfg.offset_step);

  always_ff @(posedge clk) begin
    if (cpl_we) cpl_mem[cpl_waddr] <= coef_sat;
    cpl_rdata <= cpl_mem[cpl_raddr];
  end

  always_ff @(posedge clk) begin
    if (bias_we) bias_mem[IDX_W'(row_index)] <= coef_sat;
    bias_rdata <= bias_mem[i];
  end

  always_ff @(posedge clk) begin
    if (lf_we) lf_mem[i] <= lf_wdata;
    lf_rdata <= lf_mem[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      spins         <= '0;
      offset        <= '0;
      lfsr          <= 32'd1;
      done          <= 1'b0;
      flip_done     <= 1'b0;
      flip_position <= '0;
      i             <= '0;
      j             <= '0;
      kept          <= '0;
      have          <= 1'b0;
      up            <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            flip_done     <= 1'b0;
            flip_position <= '0;
            i             <= '0;
            unique case (qda_pkg::req_e'(req_type))
              qda_pkg::REQ_WEIGHT, qda_pkg::REQ_BIAS: done <= 1'b1;
              qda_pkg::REQ_INIT: begin
                spins <= NUM_SPINS'(start_spins);
                lfsr  <= (cfg.rng_seed != 32'd0) ? cfg.rng_seed : 32'd1;
                state <= S_INIT_BRD;
              end
              qda_pkg::REQ_SWEEP: begin
                have  <= 1'b0;
                kept  <= '0;
                state <= S_ACC_RD;
              end
              default: ;
            endcase
          end
        end
        S_INIT_BRD: state <= S_INIT_BACC;
        S_INIT_BACC: begin
          acc   <= WIDE_W'(bias_rdata);
          j     <= '0;
          state <= S_INIT_CRD;
        end
        S_INIT_CRD: state <= S_INIT_CACC;
        S_INIT_CACC: begin
          if (spins[j]) acc <= acc + WIDE_W'(cpl_rdata);
          if (j == LAST) state <= S_INIT_WR;
          else begin
            j     <= j + 1'b1;
            state <= S_INIT_CRD;
          end
        end
        S_INIT_WR: begin
          if (i == LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_INIT_BRD;
          end
        end
        S_ACC_RD: begin
          lfsr  <= lfsr_step8(lfsr);
          state <= S_ACC_MUL;
        end
        S_ACC_MUL: begin
          de_r   <= spins[i] ? (FIELD_WIDTH + 1)'(lf_rdata) : -(FIELD_WIDTH + 1)'(lf_rdata);
          thr_r  <= $signed({1'b0, cfg.temperature}) * tbl_val;
          coin_r <= lfsr[31];
          state  <= S_ACC_CMP;
        end
        S_ACC_CMP: begin
          have <= have_f;
          kept <= kept_f;
          if (i != LAST) begin
            i     <= i + 1'b1;
            state <= S_ACC_RD;
          end else if (have_f) begin
            // The flipped spin's new value sets the sign of every field update.
            spins         <= spins ^ (NUM_SPINS'(1) << kept_f);
            up            <= !spins[kept_f];
            offset        <= '0;
            flip_done     <= 1'b1;
            flip_position <= 5'(kept_f);
            i             <= '0;
            state         <= S_UPD_RD;
          end else begin
            if (offset < cfg.offset_limit) offset <= off_sum[16] ? 16'hFFFF : off_sum[15:0];
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: begin
          if (i == LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_UPD_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign spin_vector = 32'(spins);
  assign offset_now  = offset;

endmodule

FILE: bench/qubo_digital_annealer_top_tb.sv
// Self-checking testbench for the QUBO annealer top level: loads, start-spin loads and sweeps
// are predicted cycle-free and compared result by result. Depends on qda_pkg and
// qubo_digital_annealer_top.
`timescale 1ns / 100ps

module qubo_digital_annealer_top_tb;

  localparam int NSPIN = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    qda_pkg::req_e   kind;
    logic [4:0]      row;
    logic [4:0]      col;
    logic [15:0]     coef;
    logic [31:0]     spins;
  } request_t;

  typedef struct {
    logic        flipped;
    logic [4:0]  pos;
    logic [31:0] spins;
    logic [15:0] offset;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [4:0] row_index = '0;
  logic [4:0] col_index = '0;
  logic signed [15:0] coef_value = '0;
  logic [31:0] start_spins = '0;
  logic done;
  logic flip_done;
  logic [4:0] flip_position;
  logic [31:0] spin_vector;
  logic [15:0] offset_now;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  qubo_digital_annealer_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .row_index(row_index), .col_index(col_index),
    .coef_value(coef_value), .start_spins(start_spins),
    .done(done), .flip_done(flip_done), .flip_position(flip_position),
    .spin_vector(spin_vector), .offset_now(offset_now),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [15:0] temp_q, step_q, limit_q;
  logic        gibbs_q;
  logic [31:0] seed_q;
  logic [31:0] spin_q;
  logic [15:0] offset_q;
  logic [31:0] lfsr_q;
  longint      field_q [NSPIN];
  longint      weight_q [NSPIN][NSPIN];
  longint      bias_q [NSPIN];
  longint      metro_noise [256];
  longint      gibbs_noise [256];

  request_t pending [$];
  outcome_t awaited [$];
  int n_sent = 0;
  int n_taken = 0;
  int gap = 0;
  int errors = 0;
  int idle_cycles = 0;
  int n_sweeps = 0;
  int n_flips = 0;

  // Natural log in Q.8 via a log2 found one bit per squaring.
  function automatic longint ln_fix(int unsigned n);
    int msb;
    longint unsigned x;
    longint r;
    msb = 0;
    for (int b = 1; b < 32; b++) if ((n >> b) != 0) msb = b;
    x = longint'(n) << (30 - msb);
    r = longint'(msb) * 65536;
    for (int k = 15; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        r = r + (longint'(1) << k);
      end
    end
    return (r * 45426 + (longint'(1) << 23)) / (longint'(1) << 24);
  endfunction

  function automatic longint clamp_field(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic logic [31:0] lfsr_next(logic [31:0] s);
    logic lsb;
    lsb = s[0];
    s = s >> 1;
    if (lsb) s = s ^ 32'h8020_0003;
    return s;
  endfunction

  task automatic anneal_predict(input request_t rq, output outcome_t res);
    longint de, thr, w;
    logic have, coin, up;
    int kept;
    logic [7:0] u;
    have = 1'b0;
    kept = 0;
    res.flipped = 1'b0;
    res.pos = '0;
    case (rq.kind)
      qda_pkg::REQ_WEIGHT: weight_q[rq.row][rq.col] = longint'($signed(rq.coef));
      qda_pkg::REQ_BIAS:   bias_q[rq.row] = longint'($signed(rq.coef));
      qda_pkg::REQ_INIT: begin
        spin_q = rq.spins;
        lfsr_q = (seed_q != 0) ? seed_q : 32'd1;
        for (int i = 0; i < NSPIN; i++) begin
          w = bias_q[i];
          for (int j = 0; j < NSPIN; j++) if (spin_q[j]) w += weight_q[i][j];
          field_q[i] = clamp_field(w);
        end
      end
      default: begin
        n_sweeps++;
        for (int i = 0; i < NSPIN; i++) begin
          de = spin_q[i] ? field_q[i] : -field_q[i];
          for (int k = 0; k < 8; k++) lfsr_q = lfsr_next(lfsr_q);
          u = lfsr_q[7:0];
          coin = lfsr_q[31];
          thr = longint'(temp_q) * (gibbs_q ? gibbs_noise[u] : metro_noise[u]);
          if ((de - longint'(offset_q)) * 256 < thr && (!have || coin)) begin
            kept = i;
            have = 1'b1;
          end
        end
        if (have) begin
          spin_q[kept] = ~spin_q[kept];
          up = spin_q[kept];
          for (int i = 0; i < NSPIN; i++) begin
            w = weight_q[i][kept];
            field_q[i] = clamp_field(field_q[i] + (up ? w : -w));
          end
          offset_q = '0;
          res.flipped = 1'b1;
          res.pos = kept[4:0];
          n_flips++;
        end else if (offset_q < limit_q) begin
          offset_q = (int'(offset_q) + int'(step_q) > 65535) ? 16'hFFFF : offset_q + step_q;
        end
      end
    endcase
    res.spins = spin_q;
    res.offset = offset_q;
  endtask

  // Request driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && n_taken == n_sent) begin
        if (gap == 0 && pending.size() > 0) send_next();
        else start <= 1'b0;
      end else if (!start) begin
        if (gap > 0) gap <= gap - 1;
        else if (pending.size() > 0) send_next();
      end
    end
  end

  task automatic send_next();
    request_t rq;
    rq = pending.pop_front();
    req_type <= rq.kind;
    row_index <= rq.row;
    col_index <= rq.col;
    coef_value <= rq.coef;
    start_spins <= rq.spins;
    start <= 1'b1;
    n_sent <= n_sent + 1;
    // Every third stretch of 32 requests runs back to back.
    gap <= ((n_sent / 32) % 3 == 0) ? 0 : $urandom_range(7);
  endtask

  // Result monitor and request capture on the rising edge.
  always @(posedge clk) begin
    request_t rq;
    outcome_t res, want;
    logic hit;
    hit = 1'b0;
    if (!rst) begin
      if (done) begin
        hit = 1'b1;
        if (awaited.size() == 0) begin
          $display("%0t: result with nothing outstanding", $time);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (flip_done !== want.flipped || flip_position !== want.pos ||
              spin_vector !== want.spins || offset_now !== want.offset) begin
            $display("%0t: mismatch exp flip=%0b pos=%0d spins=%h off=%h", $time,
                     want.flipped, want.pos, want.spins, want.offset);
            $display("%0t:          act flip=%0b pos=%0d spins=%h off=%h", $time,
                     flip_done, flip_position, spin_vector, offset_now);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        hit = 1'b1;
        rq.kind = qda_pkg::req_e'(req_type);
        rq.row = row_index;
        rq.col = col_index;
        rq.coef = coef_value;
        rq.spins = start_spins;
        anneal_predict(rq, res);
        awaited = {awaited, res};
        n_taken <= n_taken + 1;
      end
      idle_cycles <= hit ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input qda_pkg::reg_e idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      qda_pkg::REG_TEMPERATURE:  temp_q = value[15:0];
      qda_pkg::REG_OFFSET_STEP:  step_q = value[15:0];
      qda_pkg::REG_OFFSET_LIMIT: limit_q = value[15:0];
      qda_pkg::REG_ACCEPT_MODE:  gibbs_q = value[0];
      default:                   seed_q = value;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] t, input logic [15:0] s, input logic [15:0] l,
                          input logic m, input logic [31:0] sd);
    reg_write(qda_pkg::REG_TEMPERATURE, {16'h0, t});
    reg_write(qda_pkg::REG_OFFSET_STEP, {16'h0, s});
    reg_write(qda_pkg::REG_OFFSET_LIMIT, {16'h0, l});
    reg_write(qda_pkg::REG_ACCEPT_MODE, {31'h0, m});
    reg_write(qda_pkg::REG_RNG_SEED, sd);
  endtask

  task automatic queue_req(input qda_pkg::req_e k, input int r, input int c,
                           input logic [15:0] v, input logic [31:0] sp);
    request_t rq;
    rq.kind = k;
    rq.row = r[4:0];
    rq.col = c[4:0];
    rq.coef = v;
    rq.spins = sp;
    pending = {pending, rq};
  endtask

  function automatic logic [15:0] draw_coef();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  task automatic drain();
    wait (pending.size() == 0 && awaited.size() == 0 && !start);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int pick;
    queue_req(qda_pkg::REQ_INIT, 0, 0, 16'd0, $urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        queue_req(qda_pkg::REQ_WEIGHT, $urandom, $urandom, draw_coef(), $urandom);
      else if (pick < 35)
        queue_req(qda_pkg::REQ_BIAS, $urandom, $urandom, draw_coef(), $urandom);
      else if (pick < 40)
        queue_req(qda_pkg::REQ_INIT, $urandom, $urandom, 16'($urandom), $urandom);
      else
        queue_req(qda_pkg::REQ_SWEEP, $urandom, $urandom, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    temp_q = qda_pkg::TEMPERATURE_RST;
    step_q = qda_pkg::OFFSET_STEP_RST;
    limit_q = qda_pkg::OFFSET_LIMIT_RST;
    gibbs_q = 1'b0;
    seed_q = qda_pkg::RNG_SEED_RST;
    spin_q = '0;
    offset_q = '0;
    lfsr_q = 32'd1;
    for (int u = 0; u < 256; u++) begin
      metro_noise[u] = ln_fix(512) - ln_fix(2 * u + 1);
      gibbs_noise[u] = ln_fix(511 - 2 * u) - ln_fix(2 * u + 1);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every store entry is written before the first start-spin load reads it.
    for (int i = 0; i < NSPIN; i++)
      queue_req(qda_pkg::REQ_BIAS, i, $urandom, draw_coef(), $urandom);
    for (int i = 0; i < NSPIN; i++)
      for (int j = 0; j < NSPIN; j++)
        queue_req(qda_pkg::REQ_WEIGHT, i, j, draw_coef(), $urandom);
    queue_req(qda_pkg::REQ_BIAS, 0, 31, 16'h8000, '0);
    queue_req(qda_pkg::REQ_BIAS, 31, 0, 16'h7FFF, '1);
    queue_req(qda_pkg::REQ_WEIGHT, 31, 31, 16'h7FFF, '0);
    queue_req(qda_pkg::REQ_WEIGHT, 0, 0, 16'h8000, '1);
    queue_req(qda_pkg::REQ_WEIGHT, 5, 10, 16'h0000, '0);
    queue_req(qda_pkg::REQ_INIT, 0, 0, 16'd0, 32'h0000_0000);
    repeat (4) queue_req(qda_pkg::REQ_SWEEP, 0, 0, 16'd0, '0);
    queue_req(qda_pkg::REQ_INIT, 31, 31, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (4) queue_req(qda_pkg::REQ_SWEEP, 31, 31, 16'hFFFF, '1);
    queue_req(qda_pkg::REQ_INIT, 0, 0, 16'd0, 32'hA5A5_5A5A);
    repeat (6) queue_req(qda_pkg::REQ_SWEEP, 0, 0, 16'd0, '0);
    drain();

    // Zero seed, no offset growth, temperature of one.
    set_regs(16'd1, 16'd0, 16'd0, 1'b0, 32'd0);
    random_phase(80);
    drain();
    // Maximum everything with the logistic rule; the offset saturates.
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    random_phase(80);
    drain();
    // Zero temperature: only a negative dE minus offset is accepted.
    set_regs(16'd0, 16'd300, 16'd2000, 1'b0, $urandom);
    random_phase(80);
    drain();
    for (int p = 0; p < 2; p++) begin
      set_regs(16'($urandom_range(1, 8000)), 16'($urandom), 16'($urandom),
               1'($urandom), $urandom);
      random_phase(80);
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d requests, %0d sweeps with %0d flips, over six register settings.",
             n_taken, n_sweeps, n_flips);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
